// ===== sv/iee_pkg.sv =====
`default_nettype none

package iee_pkg;

	localparam int STACK_DEPTH_DEF = 16;

	// ascii codes of the accepted characters
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	// operator codes, bit 1 is the precedence level
	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_DIV0    = 2'd1;
	localparam logic [1:0] ST_STACK   = 2'd2;
	localparam logic [1:0] ST_BADCHAR = 2'd3;

	typedef struct packed {
		logic       take;
		logic       push_val;
		logic       push_op;
		logic       pop_op;
		logic       reduce_wb;
		logic       sel_div;
		logic       div_start;
		logic       set_err;
		logic [1:0] err_code;
		logic       load_out;
	} iee_cmd_t;

	typedef struct packed {
		logic is_digit;
		logic is_op;
		logic last;
		logic err_nz;
		logic vc_full;
		logic vc_lt2;
		logic oc_full;
		logic oc_zero;
		logic prec_ge;
		logic top_is_div;
		logic rhs_zero;
		logic div_done;
		logic out_free;
	} iee_sts_t;

endpackage

`default_nettype wire

// ===== sv/iee_div.sv =====
`default_nettype none

module iee_div (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [7:0] dividend,
	input  wire logic [7:0] divisor,
	output logic            done,
	output logic [7:0]      quotient
);
	import iee_pkg::*;

	localparam logic [3:0] DIV_STEPS = 4'd8;

	logic [7:0] rem_q;
	logic [7:0] quo_q;
	logic [7:0] den_q;
	logic       neg_q;
	logic [3:0] cnt_q;

	logic [7:0] a_mag;
	logic [7:0] b_mag;
	logic [8:0] shifted;
	logic [9:0] diff;
	logic       ge;

	// magnitude of -128 is 128, which still fits unsigned
	assign a_mag = dividend[7] ? 8'(-dividend) : dividend;
	assign b_mag = divisor[7] ? 8'(-divisor) : divisor;

	assign shifted = {1'b0, rem_q} << 1 | {8'd0, quo_q[7]};
	assign diff    = {1'b0, shifted} - {2'b00, den_q};
	assign ge      = ~diff[9];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= DIV_STEPS;
		end else if (start) begin
			cnt_q <= '0;
		end else if (cnt_q != DIV_STEPS) begin
			cnt_q <= cnt_q + 4'd1;
		end
	end

	// restoring division, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= a_mag;
			den_q <= b_mag;
			neg_q <= dividend[7] ^ divisor[7];
		end else if (cnt_q != DIV_STEPS) begin
			rem_q <= ge ? diff[7:0] : shifted[7:0];
			quo_q <= {quo_q[6:0], ge};
		end
	end

	assign done     = (cnt_q == DIV_STEPS);
	assign quotient = neg_q ? 8'(-quo_q) : quo_q;

endmodule

`default_nettype wire

// ===== sv/iee_dp.sv =====
`default_nettype none

module iee_dp #(
	parameter int STACK_DEPTH = iee_pkg::STACK_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire iee_pkg::iee_cmd_t cmd,
	output iee_pkg::iee_sts_t      sts,
	input  wire logic [7:0]        symbol,
	input  wire logic              last,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic signed [7:0]      value,
	output logic [1:0]             status
);
	import iee_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	logic [7:0] vs_mem [STACK_DEPTH];
	logic [1:0] os_mem [STACK_DEPTH];

	logic [7:0]    sym_q;
	logic          last_q;
	logic [CW-1:0] vc_q;
	logic [CW-1:0] oc_q;
	logic [1:0]    err_q;
	logic [7:0]    vtop_q;
	logic [7:0]    vnext_q;
	logic [1:0]    otop_q;
	logic          out_valid_q;
	logic [7:0]    value_q;
	logic [1:0]    status_q;

	logic          is_digit;
	logic          is_op;
	logic [1:0]    op_code;
	logic [7:0]    digit;
	logic [CW-1:0] vc_m1;
	logic [CW-1:0] vc_m2;
	logic [CW-1:0] oc_m1;
	logic [AW-1:0] vtop_addr;
	logic [AW-1:0] vnext_addr;
	logic [AW-1:0] otop_addr;
	logic [15:0]   prod;
	logic [7:0]    alu_res;
	logic [7:0]    wb_data;
	logic          div_done;
	logic [7:0]    div_quo;
	logic          fin_ok;
	logic [1:0]    fin_status;

	always_comb begin
		is_digit = sym_q inside {[CH_ZERO:CH_NINE]};
		is_op    = 1'b1;
		op_code  = OP_ADD;
		case (sym_q)
			CH_PLUS: begin
				op_code = OP_ADD;
			end
			CH_MINUS: begin
				op_code = OP_SUB;
			end
			CH_STAR: begin
				op_code = OP_MUL;
			end
			CH_SLASH: begin
				op_code = OP_DIV;
			end
			default: begin
				is_op = 1'b0;
			end
		endcase
	end

	assign digit = sym_q - CH_ZERO;

	// stack tops, meaningful only when the count covers them
	assign vc_m1      = vc_q - CW'(1);
	assign vc_m2      = vc_q - CW'(2);
	assign oc_m1      = oc_q - CW'(1);
	assign vtop_addr  = vc_m1[AW-1:0];
	assign vnext_addr = vc_m2[AW-1:0];
	assign otop_addr  = oc_m1[AW-1:0];

	assign prod = 16'(vnext_q) * 16'(vtop_q);

	always_comb begin
		case (otop_q)
			OP_ADD: begin
				alu_res = vnext_q + vtop_q;
			end
			OP_SUB: begin
				alu_res = vnext_q - vtop_q;
			end
			OP_MUL: begin
				alu_res = prod[7:0];
			end
			default: begin
				alu_res = div_quo;
			end
		endcase
	end

	assign wb_data = cmd.sel_div ? div_quo : alu_res;

	iee_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (vnext_q),
		.divisor  (vtop_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			sym_q  <= symbol;
			last_q <= last;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_val) begin
			vs_mem[vc_q[AW-1:0]] <= digit;
		end else if (cmd.reduce_wb) begin
			vs_mem[vnext_addr] <= wb_data;
		end
		if (cmd.push_op) begin
			os_mem[oc_q[AW-1:0]] <= op_code;
		end
		vtop_q  <= vs_mem[vtop_addr];
		vnext_q <= vs_mem[vnext_addr];
		otop_q  <= os_mem[otop_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q  <= '0;
			oc_q  <= '0;
			err_q <= ST_OK;
		end else if (cmd.load_out) begin
			vc_q  <= '0;
			oc_q  <= '0;
			err_q <= ST_OK;
		end else begin
			if (cmd.push_val) begin
				vc_q <= vc_q + CW'(1);
			end else if (cmd.reduce_wb) begin
				vc_q <= vc_m1;
			end
			if (cmd.push_op) begin
				oc_q <= oc_q + CW'(1);
			end else if (cmd.pop_op) begin
				oc_q <= oc_m1;
			end
			// first error wins
			if (cmd.set_err && err_q == ST_OK) begin
				err_q <= cmd.err_code;
			end
		end
	end

	assign fin_ok     = (err_q == ST_OK) && (vc_q == CW'(1));
	assign fin_status = (err_q != ST_OK) ? err_q : (fin_ok ? ST_OK : ST_STACK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			value_q  <= fin_ok ? vtop_q : 8'd0;
			status_q <= fin_status;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign status    = status_q;

	always_comb begin
		sts.is_digit   = is_digit;
		sts.is_op      = is_op;
		sts.last       = last_q;
		sts.err_nz     = (err_q != ST_OK);
		sts.vc_full    = (vc_q == CW'(STACK_DEPTH));
		sts.vc_lt2     = (vc_q < CW'(2));
		sts.oc_full    = (oc_q == CW'(STACK_DEPTH));
		sts.oc_zero    = (oc_q == '0);
		sts.prec_ge    = (otop_q[1] >= op_code[1]);
		sts.top_is_div = (otop_q == OP_DIV);
		sts.rhs_zero   = (vtop_q == 8'd0);
		sts.div_done   = div_done;
		sts.out_free   = ~out_valid_q | out_ready;
	end

endmodule

`default_nettype wire

// ===== sv/iee_ctrl.sv =====
`default_nettype none

module iee_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire iee_pkg::iee_sts_t sts,
	output iee_pkg::iee_cmd_t      cmd
);
	import iee_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC  = 3'd1;
	localparam logic [2:0] S_CHK  = 3'd2;
	localparam logic [2:0] S_RED  = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_WAIT = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	localparam logic PH_OP  = 1'b0;
	localparam logic PH_FIN = 1'b1;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       phase_q;
	logic       phase_d;
	logic [2:0] after_err;

	// an error ends the symbol; only the final character produces output
	assign after_err = sts.last ? S_DONE : S_IDLE;
	assign in_ready  = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = S_DEC;
				end
			end
			S_DEC: begin
				if (sts.err_nz) begin
					state_d = after_err;
				end else if (sts.is_digit) begin
					if (sts.vc_full) begin
						cmd.set_err  = 1'b1;
						cmd.err_code = ST_STACK;
						state_d      = after_err;
					end else begin
						cmd.push_val = 1'b1;
						phase_d      = PH_FIN;
						state_d      = sts.last ? S_WAIT : S_IDLE;
					end
				end else if (sts.is_op) begin
					phase_d = PH_OP;
					state_d = S_CHK;
				end else begin
					cmd.set_err  = 1'b1;
					cmd.err_code = ST_BADCHAR;
					state_d      = after_err;
				end
			end
			S_CHK: begin
				if (phase_q == PH_OP) begin
					if (!sts.oc_zero && sts.prec_ge) begin
						state_d = S_RED;
					end else if (sts.oc_full) begin
						cmd.set_err  = 1'b1;
						cmd.err_code = ST_STACK;
						state_d      = after_err;
					end else begin
						cmd.push_op = 1'b1;
						phase_d     = PH_FIN;
						state_d     = sts.last ? S_WAIT : S_IDLE;
					end
				end else if (!sts.oc_zero) begin
					state_d = S_RED;
				end else begin
					state_d = S_DONE;
				end
			end
			S_RED: begin
				cmd.pop_op = 1'b1;
				if (sts.vc_lt2) begin
					cmd.set_err  = 1'b1;
					cmd.err_code = ST_STACK;
					state_d      = after_err;
				end else if (sts.top_is_div) begin
					if (sts.rhs_zero) begin
						cmd.set_err  = 1'b1;
						cmd.err_code = ST_DIV0;
						state_d      = after_err;
					end else begin
						cmd.div_start = 1'b1;
						state_d       = S_DIV;
					end
				end else begin
					cmd.reduce_wb = 1'b1;
					state_d       = S_WAIT;
				end
			end
			S_DIV: begin
				if (sts.div_done) begin
					cmd.reduce_wb = 1'b1;
					cmd.sel_div   = 1'b1;
					state_d       = S_WAIT;
				end
			end
			S_WAIT: begin
				// lets the registered stack reads catch up with the counts
				state_d = S_CHK;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_OP;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

endmodule

`default_nettype wire

// ===== sv/infix_expression_evaluator.sv =====
// channel | signals                 | direction | transfer when
// --------+-------------------------+-----------+----------------------
// input   | in_valid, symbol, last  | in        | in_valid & in_ready
// output  | out_valid, value, status| out       | out_valid & out_ready
//
// one character at a time: a digit, a bad character or a sticky-error skip
// ends in decode, an operator push also passes the check state, and each
// stacked operator reduced (+ - *, or / via the 8-step restoring divider)
// adds a pass through the reduce states; the final character adds the
// finish plus its reductions, fewer when an error cuts it short. the loop
// is the reduce sequence around the stack memories (registered reads).
// reset (arst_n low) empties both stacks and clears the error at once.
// a result waits in the output register; the next expression proceeds
// and only stalls at its own final character while that register is full.
`default_nettype none

module infix_expression_evaluator #(
	parameter int STACK_DEPTH = iee_pkg::STACK_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  symbol,
	input  wire logic        last,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic signed [7:0] value,
	output logic [1:0]       status
);
	import iee_pkg::*;

	iee_cmd_t cmd;
	iee_sts_t sts;

	iee_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	iee_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.symbol    (symbol),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.value     (value),
		.status    (status)
	);

`ifndef SYNTHESIS
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid || out_ready))
		else $error("result loaded over an untaken result");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second character taken while one is in work");

	a_reduce_two: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.reduce_wb |-> !sts.vc_lt2)
		else $error("reduction written back with fewer than two values");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_val |-> (!sts.vc_full && !sts.err_nz))
		else $error("value pushed onto full stack or after an error");
`endif

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import iee_pkg::*;

	localparam int DEPTH = STACK_DEPTH_DEF;
	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_CHARS = 630;
	localparam int SETTLE_CYCLES = 50;

	typedef struct packed {
		logic signed [7:0] value;
		logic [1:0]        status;
	} calc_result_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [7:0]        symbol;
	logic              last;
	logic              out_valid;
	logic              out_ready;
	logic signed [7:0] value;
	logic [1:0]        status;

	infix_expression_evaluator u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.symbol   (symbol),
		.last     (last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.value    (value),
		.status   (status)
	);

	// evaluator state mirrored by the predictor
	logic [7:0]   val_stk [DEPTH];
	logic [1:0]   op_stk [DEPTH];
	int           val_cnt = 0;
	int           op_cnt = 0;
	logic [1:0]   err_code = ST_OK;
	calc_result_t pending_results [$];

	int mismatches = 0;
	int idle_cycles = 0;
	int chars_sent = 0;
	int rx_hold = 0;
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic void flag_error(logic [1:0] code);
		if (err_code == ST_OK)
			err_code = code;
	endfunction

	// pop one operator and fold the top two values
	function automatic void reduce_top();
		logic signed [7:0] lhs;
		logic signed [7:0] rhs;
		logic [1:0]        op;
		logic [7:0]        res;
		int                quot;
		if (op_cnt == 0)
			return;
		op_cnt--;
		op = op_stk[op_cnt];
		if (val_cnt < 2) begin
			flag_error(ST_STACK);
			return;
		end
		lhs = val_stk[val_cnt - 2];
		rhs = val_stk[val_cnt - 1];
		res = 8'd0;
		case (op)
			OP_ADD: res = lhs + rhs;
			OP_SUB: res = lhs - rhs;
			OP_MUL: res = lhs * rhs;
			OP_DIV: begin
				if (rhs == 0) begin
					flag_error(ST_DIV0);
					return;
				end
				quot = int'(lhs) / int'(rhs);
				res = quot[7:0];
			end
		endcase
		val_cnt--;
		val_stk[val_cnt - 1] = res;
	endfunction

	function automatic void take_symbol(logic [7:0] ch);
		logic [1:0] code;
		if (ch >= CH_ZERO && ch <= CH_NINE) begin
			if (val_cnt >= DEPTH) begin
				flag_error(ST_STACK);
			end else begin
				val_stk[val_cnt] = ch - CH_ZERO;
				val_cnt++;
			end
			return;
		end
		case (ch)
			CH_PLUS:  code = OP_ADD;
			CH_MINUS: code = OP_SUB;
			CH_STAR:  code = OP_MUL;
			CH_SLASH: code = OP_DIV;
			default: begin
				flag_error(ST_BADCHAR);
				return;
			end
		endcase
		// bit 1 of the code is the precedence level
		while (err_code == ST_OK && op_cnt > 0 && op_stk[op_cnt - 1][1] >= code[1])
			reduce_top();
		if (err_code != ST_OK)
			return;
		if (op_cnt >= DEPTH) begin
			flag_error(ST_STACK);
		end else begin
			op_stk[op_cnt] = code;
			op_cnt++;
		end
	endfunction

	function automatic void evaluate_char(logic [7:0] ch, logic fin);
		calc_result_t r;
		if (err_code == ST_OK)
			take_symbol(ch);
		if (!fin)
			return;
		while (err_code == ST_OK && op_cnt > 0)
			reduce_top();
		if (err_code == ST_OK && val_cnt != 1)
			flag_error(ST_STACK);
		r.value = (err_code == ST_OK) ? val_stk[0] : 8'sd0;
		r.status = err_code;
		pending_results.push_back(r);
		val_cnt = 0;
		op_cnt = 0;
		err_code = ST_OK;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] rand_digit();
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] rand_operator();
		case ($urandom_range(0, 3))
			0: return CH_PLUS;
			1: return CH_MINUS;
			2: return CH_STAR;
			default: return CH_SLASH;
		endcase
	endfunction

	// entered right after a transfer (or at start), so the next falling edge
	// either lowers valid for a gap or presents the next character
	task automatic send_char(input logic [7:0] ch, input logic fin);
		int gap;
		gap = tx_steady ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		symbol <= ch;
		last <= fin;
		do
			@(posedge clk);
		while (!in_ready);
		evaluate_char(ch, fin);
		chars_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], i == s.len() - 1);
	endtask

	task automatic wait_results_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_random_expr();
		logic [7:0] seq [$];
		int         kind;
		int         n;
		kind = $urandom_range(0, 99);
		if (kind < 75) begin
			// well-formed: digit (op digit)*, mostly short
			n = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 10) : $urandom_range(0, 3);
			seq.push_back(rand_digit());
			repeat (n) begin
				seq.push_back(rand_operator());
				seq.push_back(rand_digit());
			end
			if ($urandom_range(0, 19) == 0)
				seq[$urandom_range(0, seq.size() - 1)] = 8'($urandom_range(0, 255));
		end else if (kind < 88) begin
			repeat ($urandom_range(1, 8))
				seq.push_back($urandom_range(0, 1) ? rand_digit() : rand_operator());
		end else if (kind < 94) begin
			// long digit runs (14 to 18) can walk the value stack past full
			repeat ($urandom_range(14, 18))
				seq.push_back(rand_digit());
		end else begin
			repeat ($urandom_range(1, 5))
				seq.push_back(8'($urandom_range(0, 255)));
		end
		foreach (seq[i])
			send_char(seq[i], i == seq.size() - 1);
	endtask

	task automatic test_operator_precedence();
		send_text("9*9*9-8/3");
		send_text("8-2-1");
		send_text("0-8*8*2/3");
		wait_results_drained();
	endtask

	task automatic test_error_cases();
		send_text("5/0");
		send_text("+");
		send_text("12");
		// sticky error, following characters are ignored
		send_char("3", 1'b0);
		send_char(8'hFF, 1'b0);
		send_char(CH_PLUS, 1'b1);
		// bad character on the final transfer
		send_char("4", 1'b0);
		send_char(CH_PLUS, 1'b0);
		send_char(8'h00, 1'b1);
	endtask

	task automatic test_back_to_back();
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		repeat (8) send_random_expr();
		rx_steady = 1'b0;
		repeat (6) send_random_expr();
		tx_steady = 1'b0;
	endtask

	task automatic test_random_expressions();
		int start;
		start = chars_sent;
		while (chars_sent - start < RANDOM_CHARS) begin
			tx_steady = ($urandom_range(0, 15) == 0);
			rx_steady = ($urandom_range(0, 15) == 0);
			send_random_expr();
			if ($urandom_range(0, 29) == 0)
				wait_results_drained();
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	always @(negedge clk) begin
		if (rx_hold > 0) begin
			rx_hold--;
		end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
			out_ready <= 1'b0;
			rx_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : result_check
		calc_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result value %0d status %0d", $time, value, status);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (value !== want.value) begin
					$display("%0t: value expected %0d actual %0d", $time, want.value, value);
					mismatches++;
				end
				if (status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status, status);
					mismatches++;
				end
			end
		end
	end

	// no transfer on either side for too long means a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		symbol = 8'd0;
		last = 1'b0;
		out_ready = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_operator_precedence();
		test_error_cases();
		test_back_to_back();
		test_random_expressions();

		wait_results_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
